### rtl/core/arc_pkg.sv
// Package for the allocation region checker: table sizes, op and verdict codes.
// Used by every module of the block; depends on nothing.
package arc_pkg;
  // Both tables are built from the same row of cells, so they share one depth.
  localparam int RowEntries   = 64;
  localparam int RowCntW      = $clog2(RowEntries + 1);
  localparam int LiveEntries  = RowEntries;
  localparam int FreedEntries = RowEntries;
  localparam int AddrBits     = 32;
  localparam int LiveCntW     = $clog2(LiveEntries + 1);
  localparam int FreedCntW    = $clog2(FreedEntries + 1);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;

  localparam logic [2:0] V_ALLOC_KEPT   = 3'd0;
  localparam logic [2:0] V_ALLOC_DROP   = 3'd1;
  localparam logic [2:0] V_FREED        = 3'd2;
  localparam logic [2:0] V_FREE_NOMATCH = 3'd3;
  localparam logic [2:0] V_FREED_NOREC  = 3'd4;
  localparam logic [2:0] V_LIVE         = 3'd5;
  localparam logic [2:0] V_ALREADY_FREE = 3'd6;
  localparam logic [2:0] V_UNINIT       = 3'd7;

  // Control broadcast from the sequencer to every cell of a row.
  typedef struct packed {
    logic            load;    // write new entry at append position
    logic            remove;  // removal flag; cells ignore it and shift by shift_mask
    logic [AddrBits-1:0] addr;
    logic [31:0]     len;
  } arc_ctl_t;

  // Access [a, a+len) inside region [s, s+sz), no wrap.
  function automatic logic covers(input logic [AddrBits-1:0] s, input logic [31:0] sz,
                                  input logic [AddrBits-1:0] a, input logic [31:0] len);
    logic [AddrBits:0] d;
    logic [32:0]       r;
    begin
      d = {1'b0, a} - {1'b0, s};
      r = {1'b0, sz} - {1'b0, len};
      covers = (a >= s) && (len <= sz) && ({{(AddrBits > 32 ? AddrBits-32 : 1){1'b0}}, r}
               >= {{(AddrBits > 32 ? 1 : 33-AddrBits){1'b0}}, d});
    end
  endfunction
endpackage

### rtl/core/arc_cell.sv
// One table cell: holds a region (its valid flag is the row's count) and compares against the request.
// Depends on arc_pkg.
module arc_cell import arc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  arc_ctl_t            ctl,
  input  logic                append_here, // this cell is the append position
  input  logic                shift_in,    // take upper neighbor's data
  input  logic [AddrBits-1:0] nb_start,
  input  logic [31:0]         nb_size,
  output logic [AddrBits-1:0] start_o,
  output logic [31:0]         size_o,
  output logic                eq_o,        // start matches request address
  output logic                cov_o        // region covers the access
);
  logic [AddrBits-1:0] start_r;
  logic [31:0]         size_r;

  always_ff @(posedge clk) begin
    if (ctl.load && append_here) begin
      start_r <= ctl.addr;
      size_r  <= ctl.len;
    end else if (shift_in) begin
      start_r <= nb_start;
      size_r  <= nb_size;
    end
  end

  assign start_o = start_r;
  assign size_o  = size_r;
  assign eq_o    = (start_r == ctl.addr);
  assign cov_o   = covers(start_r, size_r, ctl.addr, ctl.len);
  logic unused;
  assign unused = rst_n ^ ctl.remove;
endmodule

### rtl/core/arc_row.sv
// A row of RowEntries cells with occupancy count; reports match and cover vectors.
// Depends on arc_pkg and arc_cell.
module arc_row import arc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  arc_ctl_t                 ctl,
  input  logic [RowCntW-1:0]       count,
  input  logic [RowEntries-1:0]    shift_mask, // cells that take their upper neighbor
  output logic [AddrBits-1:0]      start_o [RowEntries],
  output logic [31:0]              size_o  [RowEntries],
  output logic [RowEntries-1:0]    eq_o,
  output logic [RowEntries-1:0]    cov_o
);
  for (genvar i = 0; i < RowEntries; i++) begin : g_cell
    logic [AddrBits-1:0] nb_s;
    logic [31:0]         nb_z;
    logic                e, c;
    if (i == RowEntries-1) begin : g_top
      assign nb_s = start_o[i];
      assign nb_z = size_o[i];
    end else begin : g_mid
      assign nb_s = start_o[i+1];
      assign nb_z = size_o[i+1];
    end
    arc_cell u_cell (
      .clk, .rst_n, .ctl,
      .append_here (count == RowCntW'(i)),
      .shift_in    (shift_mask[i]),
      .nb_start    (nb_s),
      .nb_size     (nb_z),
      .start_o     (start_o[i]),
      .size_o      (size_o[i]),
      .eq_o        (e),
      .cov_o       (c)
    );
    assign eq_o[i]  = e && (count > RowCntW'(i));
    assign cov_o[i] = c && (count > RowCntW'(i));
  end
endmodule

### rtl/core/allocation_region_checker_unit.sv
// Allocation region checker: live and freed region tables as rows of cells.
// Depends on arc_pkg, arc_row, arc_cell.
// A request is registered when taken; the verdict and its strobe are registered
// from the execute state. Busy blocks new requests: the accepting cycle registers the
//   request, then the execute state compares every cell and applies the update/shift.
// Reset (synchronous, rst_n low) empties both tables at once; no clearing pass.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module allocation_region_checker_unit import arc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_region_address,
  input  logic [31:0] in_length,
  output logic        out_valid,
  output logic [2:0]  out_verdict
);
  typedef enum logic [1:0] {S_IDLE = 2'b01, S_EXEC = 2'b10} state_t;

  state_t               state_r;
  logic [1:0]           op_r;
  arc_ctl_t             ctl_r;
  logic [LiveCntW-1:0]  live_cnt_r;
  logic [FreedCntW-1:0] freed_cnt_r;
  logic                 out_valid_r;
  logic [2:0]           verdict_r;

  logic [AddrBits-1:0]  l_start [LiveEntries];
  logic [31:0]          l_size  [LiveEntries];
  logic [AddrBits-1:0]  f_start [FreedEntries];
  logic [31:0]          f_size  [FreedEntries];
  logic [LiveEntries-1:0]  l_eq, l_cov, l_shift, first_hit;
  logic [FreedEntries-1:0] f_eq, f_cov;
  logic [AddrBits-1:0]  hit_start;
  logic [31:0]          hit_size;
  logic                 exec, is_free, is_alloc, hit_any, f_full, l_full;
  arc_ctl_t             l_ctl, f_ctl;

  assign busy      = (state_r != S_IDLE);
  assign exec      = (state_r == S_EXEC);
  assign is_alloc  = (op_r == OP_ALLOC);
  assign is_free   = (op_r == OP_FREE);
  assign l_full    = (live_cnt_r == LiveCntW'(LiveEntries));
  assign f_full    = (freed_cnt_r == FreedCntW'(FreedEntries));

  // Oldest matching live entry: isolate lowest set bit.
  assign first_hit = l_eq & (~l_eq + LiveEntries'(1));
  assign hit_any   = |l_eq;
  // Cells at or above the hit take their upper neighbor.
  assign l_shift   = (exec && is_free && hit_any) ? ~(first_hit - LiveEntries'(1)) : '0;

  always_comb begin
    hit_start = '0;
    hit_size  = '0;
    for (int i = 0; i < LiveEntries; i++) begin
      if (first_hit[i]) begin
        hit_start = l_start[i];
        hit_size  = l_size[i];
      end
    end
  end

  always_comb begin
    l_ctl        = ctl_r;
    l_ctl.load   = exec && is_alloc && !l_full;
    l_ctl.remove = exec && is_free && hit_any;
    f_ctl        = ctl_r;
    f_ctl.addr   = exec && is_free ? hit_start : ctl_r.addr;
    f_ctl.len    = exec && is_free ? hit_size : ctl_r.len;
    f_ctl.load   = exec && is_free && hit_any && !f_full;
    f_ctl.remove = 1'b0;
  end

  arc_row u_live (
    .clk, .rst_n, .ctl(l_ctl), .count(live_cnt_r), .shift_mask(l_shift),
    .start_o(l_start), .size_o(l_size), .eq_o(l_eq), .cov_o(l_cov)
  );
  // The freed row compares against the request too (addr/len of ctl_r on checks).
  arc_row u_freed (
    .clk, .rst_n, .ctl(f_ctl), .count(freed_cnt_r), .shift_mask('0),
    .start_o(f_start), .size_o(f_size), .eq_o(f_eq), .cov_o(f_cov)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_cnt_r  <= '0;
      freed_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (is_alloc) begin
            if (!l_full) live_cnt_r <= live_cnt_r + LiveCntW'(1);
          end else if (is_free) begin
            if (hit_any) begin
              live_cnt_r <= live_cnt_r - LiveCntW'(1);
              if (!f_full) freed_cnt_r <= freed_cnt_r + FreedCntW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold the request payload and work out the verdict.
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      op_r          <= in_op;
      ctl_r.addr    <= AddrBits'(in_region_address);
      ctl_r.len     <= in_length;
      ctl_r.load    <= 1'b0;
      ctl_r.remove  <= 1'b0;
    end
    if (exec) begin
      if (is_alloc)      verdict_r <= l_full ? V_ALLOC_DROP : V_ALLOC_KEPT;
      else if (is_free)  verdict_r <= !hit_any ? V_FREE_NOMATCH :
                                      (f_full ? V_FREED_NOREC : V_FREED);
      else if (|l_cov)   verdict_r <= V_LIVE;
      else if (|f_cov)   verdict_r <= V_ALREADY_FREE;
      else               verdict_r <= V_UNINIT;
    end
  end

  logic unused;
  assign unused = ^f_eq ^ ^f_start[0] ^ ^f_size[0];

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r <= LiveCntW'(LiveEntries)) else $error("live count overflow");
  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    freed_cnt_r <= FreedCntW'(FreedEntries)) else $error("freed count overflow");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid) else $error("missing verdict strobe");
  a_onehit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_hit)) else $error("multiple first hits");
endmodule

### tb/sv/arc_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the allocation region checker: region-table predictor and
// queue of expected verdicts. Depends on arc_pkg.
class arc_scoreboard;
  logic [31:0] live_start[$];
  logic [31:0] live_size[$];
  logic [31:0] freed_start[$];
  logic [31:0] freed_size[$];
  logic [2:0]  verdict_q[$];
  int          errors;
  int          checked;
  int          verdict_seen[8];

  function new();
    errors = 0;
    checked = 0;
    foreach (verdict_seen[i]) verdict_seen[i] = 0;
  endfunction

  // Inclusive-start, no-wrap containment of [a, a+len) in [s, s+sz).
  function bit region_holds(logic [31:0] s, logic [31:0] sz,
                            logic [31:0] a, logic [31:0] len);
    if (a < s || len > sz) return 0;
    return (a - s) <= (sz - len);
  endfunction

  // Apply one accepted request and queue its verdict.
  function void note_request(logic [1:0] op, logic [31:0] addr, logic [31:0] len);
    logic [2:0] v;
    int hit;
    hit = -1;
    if (op == arc_pkg::OP_ALLOC) begin
      if (live_start.size() < arc_pkg::LiveEntries) begin
        live_start = {live_start, addr};
        live_size = {live_size, len};
        v = arc_pkg::V_ALLOC_KEPT;
      end else begin
        v = arc_pkg::V_ALLOC_DROP;
      end
    end else if (op == arc_pkg::OP_FREE) begin
      for (int i = 0; i < live_start.size(); i++) begin
        if (live_start[i] == addr) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        v = arc_pkg::V_FREE_NOMATCH;
      end else begin
        if (freed_start.size() < arc_pkg::FreedEntries) begin
          freed_start = {freed_start, live_start[hit]};
          freed_size = {freed_size, live_size[hit]};
          v = arc_pkg::V_FREED;
        end else begin
          v = arc_pkg::V_FREED_NOREC;
        end
        live_start.delete(hit);
        live_size.delete(hit);
      end
    end else begin
      v = arc_pkg::V_UNINIT;
      foreach (live_start[i]) begin
        if (region_holds(live_start[i], live_size[i], addr, len)) begin
          v = arc_pkg::V_LIVE;
          break;
        end
      end
      if (v == arc_pkg::V_UNINIT) begin
        foreach (freed_start[i]) begin
          if (region_holds(freed_start[i], freed_size[i], addr, len)) begin
            v = arc_pkg::V_ALREADY_FREE;
            break;
          end
        end
      end
    end
    verdict_q = {verdict_q, v};
  endfunction

  function void check_verdict(logic [2:0] got);
    logic [2:0] want;
    if (verdict_q.size() == 0) begin
      $error("verdict %0d arrived with nothing expected", got);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    checked++;
    verdict_seen[want]++;
    if (got !== want) begin
      $error("verdict mismatch: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

### tb/sv/tb_allocation_region_checker_unit.sv
`timescale 1ns / 1ps
// Top-level testbench for allocation_region_checker_unit: directed and random
// requests, checked by arc_scoreboard. Depends on arc_pkg and arc_scoreboard.
module tb_allocation_region_checker_unit;
  import arc_pkg::*;

  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3; // treated as a check by the block
  localparam int RandRequests = 930;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_region_address;
  logic [31:0] in_length;
  logic        out_valid;
  logic [2:0]  out_verdict;

  arc_scoreboard region_sb;
  int          sent;
  logic [31:0] addr_pool[$];   // starts handed out, so frees and checks hit

  allocation_region_checker_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_region_address(in_region_address), .in_length(in_length),
    .out_valid(out_valid), .out_verdict(out_verdict)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold the run to a fixed ceiling sized for ~1000 requests at worst-case gaps.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Sample results at the rising edge; the strobe lasts one cycle only.
  always @(posedge clk) begin
    if (rst_n && out_valid) region_sb.check_verdict(out_verdict);
  end

  // Drive one request: idle a random gap, raise start at a falling edge,
  // hold until a rising edge sees busy low, then drop start.
  task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [31:0] len,
                              bit no_gap = 0);
    int gap;
    bit taken;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    repeat (gap) @(negedge clk);
    in_op = op;
    in_region_address = addr;
    in_length = len;
    start = 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1;
        region_sb.note_request(op, addr, len);
        sent++;
      end
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  // Pick an address near a known region start, or anywhere.
  function automatic logic [31:0] near_addr();
    if (addr_pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
    return addr_pool[$urandom_range(0, addr_pool.size() - 1)] + $urandom_range(0, 40);
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] l;
    int pick;
    start = 1'b0;
    in_op = OP_ALLOC;
    in_region_address = '0;
    in_length = '0;
    rst_n = 1'b0;
    sent = 0;
    region_sb = new();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty tables, extremes, zero sizes, wrap at top, duplicates.
    send_request(OP_CHECK, 32'h0, 32'h0);
    send_request(OP_FREE, 32'h1000, 32'h0);
    send_request(OP_ALLOC, 32'h1000, 32'h100);
    send_request(OP_ALLOC, 32'h1000, 32'h10);              // duplicate start
    send_request(OP_CHECK, 32'h1000, 32'h100);
    send_request(OP_CHECK, 32'h1100, 32'h0);               // zero length at end
    send_request(OP_CHECK, 32'h10F0, 32'h20);              // access runs past end
    send_request(OP_FREE, 32'h1000, 32'hFFFF_FFFF);        // frees the oldest
    send_request(OP_CHECK, 32'h1080, 32'h10);              // now already freed
    send_request(OP_CHECK, 32'h1000, 32'h10);              // younger copy still live
    send_request(OP_ALLOC, 32'h2000, 32'h0);               // zero-size region
    send_request(OP_CHECK, 32'h2000, 32'h0);
    send_request(OP_CHECK, 32'h2000, 32'h1);
    send_request(OP_ALLOC, 32'hFFFF_FF00, 32'hFFFF_FFFF);  // end past the top
    send_request(OP_CHECK, 32'hFFFF_FFFF, 32'h1);
    send_request(OP_CHECK, 32'hFFFF_FFF0, 32'h100);
    send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_UNUSED, 32'h5555_AAAA, 32'hAAAA_5555, 1);
    send_request(OP_FREE, 32'hFFFF_FF00, 32'h0, 1);
    send_request(OP_FREE, 32'h0, 32'h0, 1);

    // Random: mostly alloc/free/check around known starts; tables fill and
    // drain in waves, so both full cases are reached.
    for (int n = 0; n < RandRequests; n++) begin
      pick = $urandom_range(0, 99);
      // bias to fill during the first half of each 200-request wave
      if ((n % 200) < 100) pick = pick * 6 / 10;
      if (pick < 35) begin
        a = (addr_pool.size() > 0 && $urandom_range(0, 4) == 0) ?
            addr_pool[$urandom_range(0, addr_pool.size() - 1)] : $urandom();
        if ($urandom_range(0, 3) == 0) a = a & 32'hFFFF_FF00;
        l = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 64);
        addr_pool = {addr_pool, a};
        if (addr_pool.size() > 200) void'(addr_pool.pop_front());
        send_request(OP_ALLOC, a, l, $urandom_range(0, 4) == 0);
      end else if (pick < 60) begin
        send_request(OP_FREE, near_addr() & 32'hFFFF_FFC0 | ($urandom_range(0, 1) ?
                     32'h0 : $urandom_range(0, 63)), $urandom(), $urandom_range(0, 4) == 0);
      end else begin
        l = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 48);
        send_request($urandom_range(0, 9) == 0 ? OP_UNUSED : OP_CHECK, near_addr(), l,
                     $urandom_range(0, 4) == 0);
      end
    end

    // Drain: wait on the queue, then allow the pipeline latency to pass.
    while (region_sb.verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests, checked %0d verdicts; alloc drop %0d, free unrecorded %0d,",
             sent, region_sb.checked, region_sb.verdict_seen[V_ALLOC_DROP],
             region_sb.verdict_seen[V_FREED_NOREC]);
    $display("live hits %0d, freed hits %0d, misses %0d, unmatched frees %0d",
             region_sb.verdict_seen[V_LIVE], region_sb.verdict_seen[V_ALREADY_FREE],
             region_sb.verdict_seen[V_UNINIT], region_sb.verdict_seen[V_FREE_NOMATCH]);
    if (region_sb.errors == 0 && region_sb.verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
